// ===== sv/rans_interleaved_encoder_top_defines.svh =====
// Assertion macros shared by the rANS encoder checker.
// Depends on aclk and aresetn being visible where the macros are used.
`ifndef RANS_INTERLEAVED_ENCODER_TOP_DEFINES_SVH
`define RANS_INTERLEAVED_ENCODER_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RIE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RIE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rie_pkg.sv =====
// Types, constants and the divider step function for the rANS encoder.
// No dependencies.
`default_nettype none

package rie_pkg;

    localparam int STATE_W    = 31;
    localparam int FREQ_W     = 16;
    localparam int CHUNK_W    = 16;
    localparam int LANE_IDX_W = 3;
    localparam int DIV_STAGES = 4;
    localparam int DIV_BITS   = 8;

    localparam logic [STATE_W-1:0] STATE_RESET = 31'd32768;

    localparam logic KIND_CHUNK = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [FREQ_W-1:0] cum_freq;
        logic [FREQ_W-1:0] total;
        logic [1:0]        lane;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         out_lane;
        logic [STATE_W-1:0] value;
        logic               end_of_block;
    } out_item_t;

    // Write-back transaction leaving the pipeline.
    typedef struct packed {
        logic                  valid;
        logic [LANE_IDX_W-1:0] lane;
        logic                  last;
        logic                  upd;
        logic                  emit;
        logic [CHUNK_W-1:0]    chunk;
        logic [STATE_W-1:0]    nstate;
    } wb_t;

    typedef struct packed {
        logic [FREQ_W-1:0]   rem;
        logic [DIV_BITS-1:0] q;
    } div_step_t;

    // Eight restoring division steps; the remainder stays below d if d is nonzero and rem < d.
    function automatic div_step_t div8(input logic [FREQ_W-1:0] rem,
                                       input logic [DIV_BITS-1:0] bits,
                                       input logic [FREQ_W-1:0] d);
        logic [FREQ_W:0]   r;
        logic [FREQ_W-1:0] cur;
        logic [DIV_BITS-1:0] q;
        div_step_t res;
        cur = rem;
        q   = '0;
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            r = {cur, bits[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
            cur = r[FREQ_W-1:0];
        end
        res.rem = cur;
        res.q   = q;
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/rie_pipe.sv =====
// Arithmetic pipeline: renormalisation test, pipelined divider, state update.
// Depends on rie_pkg.
`default_nettype none

module rie_pipe #(
    parameter int LANES = 4
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire rie_pkg::in_item_t            in_data,
    input  wire logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] in_lane,
    input  wire logic [rie_pkg::STATE_W-1:0]  in_x,
    output logic [LANES-1:0]                  busy_lanes,
    output logic                              any_valid,
    output logic                              any_last,
    output rie_pkg::wb_t                      wb
);

    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int NST    = 2 + (rie_pkg::DIV_STAGES + 1) + 1;
    localparam int DIVW   = rie_pkg::DIV_STAGES * rie_pkg::DIV_BITS;

    typedef struct packed {
        logic [LANE_W-1:0] lane;
        logic              last;
    } tag_t;

    typedef struct packed {
        logic [15:0] f;
        logic [15:0] c;
        logic [15:0] t;
        logic        zero;
        logic [30:0] x;
    } a_t;

    typedef struct packed {
        logic [15:0] f;
        logic [15:0] c;
        logic [15:0] t;
        logic        zero;
        logic [30:0] x;
        logic [47:0] prod;
    } b_t;

    typedef struct packed {
        logic            zero;
        logic            emit;
        logic [15:0]     chunk;
        logic [15:0]     f;
        logic [15:0]     c;
        logic [15:0]     t;
        logic [DIVW-1:0] dividend;
        logic [15:0]     rem;
        logic [DIVW-1:0] q;
    } d_t;

    logic [NST-1:0] vld_reg;
    tag_t           tag_reg [NST];
    a_t             a_reg;
    b_t             b_reg;
    d_t             dv_reg  [rie_pkg::DIV_STAGES+1];
    d_t             c_next;
    d_t             dv_next [rie_pkg::DIV_STAGES];
    logic           m_upd_reg;
    logic           m_emit_reg;
    logic [15:0]    m_chunk_reg;
    logic [30:0]    m_state_reg;
    logic [31:0]    xp1;
    logic [46:0]    qt;
    logic [47:0]    sum;
    logic           emit_c;
    d_t             dl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_reg[0] <= '{lane: in_lane, last: in_data.last};
            for (int k = 1; k < NST; k++) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    always_comb begin
        busy_lanes = '0;
        any_last   = 1'b0;
        for (int k = 0; k < NST; k++) begin
            if (vld_reg[k]) begin
                busy_lanes[tag_reg[k].lane] = 1'b1;
                any_last = any_last | tag_reg[k].last;
            end
        end
        any_valid = |vld_reg;
    end

    // Renormalisation test without a divider: x >= floor(2^31*f/t) is (x+1)*t > 2^31*f.
    assign xp1    = {1'b0, a_reg.x} + 32'd1;
    assign emit_c = !b_reg.zero && (b_reg.prod > {1'b0, b_reg.f, 31'b0});

    always_comb begin
        c_next.zero     = b_reg.zero;
        c_next.emit     = emit_c;
        c_next.chunk    = b_reg.x[15:0];
        c_next.f        = b_reg.f;
        c_next.c        = b_reg.c;
        c_next.t        = b_reg.t;
        c_next.dividend = emit_c ? {17'b0, b_reg.x[30:16]} : {1'b0, b_reg.x};
        c_next.rem      = '0;
        c_next.q        = '0;
    end

    for (genvar k = 0; k < rie_pkg::DIV_STAGES; k++) begin : g_div
        rie_pkg::div_step_t step;
        assign step = rie_pkg::div8(dv_reg[k].rem,
                                    dv_reg[k].dividend[DIVW-1 -: rie_pkg::DIV_BITS],
                                    dv_reg[k].f);
        always_comb begin
            dv_next[k]          = dv_reg[k];
            dv_next[k].dividend = dv_reg[k].dividend << rie_pkg::DIV_BITS;
            dv_next[k].rem      = step.rem;
            dv_next[k].q        = {dv_reg[k].q[DIVW-rie_pkg::DIV_BITS-1:0], step.q};
        end
    end

    assign dl  = dv_reg[rie_pkg::DIV_STAGES];
    assign qt  = dl.q[30:0] * dl.t;
    assign sum = {1'b0, qt} + {32'b0, dl.rem} + {32'b0, dl.c};

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg.f    <= in_data.freq;
            a_reg.c    <= in_data.cum_freq;
            a_reg.t    <= in_data.total;
            a_reg.zero <= (in_data.freq == '0) || (in_data.total == '0);
            a_reg.x    <= in_x;

            b_reg.f    <= a_reg.f;
            b_reg.c    <= a_reg.c;
            b_reg.t    <= a_reg.t;
            b_reg.zero <= a_reg.zero;
            b_reg.x    <= a_reg.x;
            b_reg.prod <= xp1 * a_reg.t;

            dv_reg[0] <= c_next;
            for (int k = 0; k < rie_pkg::DIV_STAGES; k++) begin
                dv_reg[k+1] <= dv_next[k];
            end

            m_upd_reg   <= !dl.zero;
            m_emit_reg  <= dl.emit;
            m_chunk_reg <= dl.chunk;
            m_state_reg <= sum[30:0];
        end
    end

    always_comb begin
        wb.valid  = vld_reg[NST-1];
        wb.lane   = rie_pkg::LANE_IDX_W'(tag_reg[NST-1].lane);
        wb.last   = tag_reg[NST-1].last;
        wb.upd    = m_upd_reg;
        wb.emit   = m_emit_reg;
        wb.chunk  = m_chunk_reg;
        wb.nstate = m_state_reg;
    end

endmodule

`default_nettype wire

// ===== sv/rie_emit.sv =====
// Result queue: a write-back's chunk and/or final states, one per ready cycle.
// Depends on rie_pkg.
`default_nettype none

module rie_emit #(
    parameter int LANES = 4
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    load,
    output logic                                         load_ready,
    input  wire rie_pkg::wb_t                            wb,
    input  wire logic [LANES-1:0][rie_pkg::STATE_W-1:0]  finals,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output rie_pkg::out_item_t                           m_data
);

    localparam int QD    = LANES + 1;
    localparam int CNT_W = $clog2(QD + 1);

    rie_pkg::out_item_t q_reg  [QD];
    rie_pkg::out_item_t q_next [QD];
    rie_pkg::out_item_t fin_item [LANES];
    rie_pkg::out_item_t chunk_item;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    always_comb begin
        chunk_item.kind         = rie_pkg::KIND_CHUNK;
        chunk_item.out_lane     = wb.lane[1:0];
        chunk_item.value        = {15'b0, wb.chunk};
        chunk_item.end_of_block = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            fin_item[i].kind         = rie_pkg::KIND_FINAL;
            fin_item[i].out_lane     = 2'(i);
            fin_item[i].value        = finals[i];
            fin_item[i].end_of_block = (i == LANES - 1);
        end
    end

    assign load_ready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_ready);

    always_comb begin
        for (int k = 0; k < QD; k++) begin
            q_next[k] = q_reg[k];
        end
        cnt_next = cnt_reg;
        if (load) begin
            for (int k = 0; k < QD; k++) begin
                q_next[k] = '0;
                if (wb.emit) begin
                    if (k == 0) begin
                        q_next[k] = chunk_item;
                    end else if (wb.last) begin
                        q_next[k] = fin_item[k-1];
                    end
                end else if (wb.last && k < LANES) begin
                    q_next[k] = fin_item[k];
                end
            end
            cnt_next = CNT_W'(wb.emit) + (wb.last ? CNT_W'(LANES) : '0);
        end else if ((cnt_reg != '0) && m_ready) begin
            for (int k = 0; k < QD - 1; k++) begin
                q_next[k] = q_reg[k+1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < QD; k++) begin
            q_reg[k] <= q_next[k];
        end
    end

    assign m_valid = (cnt_reg != '0);
    assign m_data  = q_reg[0];

endmodule

`default_nettype wire

// ===== sv/rans_interleaved_encoder_top.sv =====
// Throughput: one transaction per cycle while its lane differs from the eight in the
// pipeline and the result queue can take the write-back; a transaction on a lane still
// in flight waits until that lane is written back. A last transaction waits for an
// empty pipeline and nothing enters behind it until it leaves; its final states then
// leave one per cycle while m_ready is high. The divider sets the pipeline depth.
// Reset (synchronous, aresetn low): every lane state to 32768, pipeline and queue empty.
`default_nettype none

module rans_interleaved_encoder_top #(
    parameter int LANES = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire rie_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rie_pkg::out_item_t      m_data
);

    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

    logic [LANES-1:0][rie_pkg::STATE_W-1:0] state_reg;
    logic [LANES-1:0][rie_pkg::STATE_W-1:0] state_next;
    logic [LANES-1:0][rie_pkg::STATE_W-1:0] finals;
    logic [LANE_W-1:0]                      in_lane;
    logic [LANES-1:0]                       busy_lanes;
    logic                                   any_valid;
    logic                                   any_last;
    logic                                   hazard;
    logic                                   adv;
    logic                                   emit_ready;
    logic                                   wb_fire;
    rie_pkg::wb_t                           wb;

    assign in_lane = LANE_W'(s_data.lane % LANES);
    assign hazard  = busy_lanes[in_lane] | any_last | (s_data.last & any_valid);
    assign adv     = !wb.valid | emit_ready;
    assign s_ready = adv & !hazard;
    assign wb_fire = wb.valid & adv;

    rie_pipe #(.LANES(LANES)) u_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_valid & s_ready),
        .in_data    (s_data),
        .in_lane    (in_lane),
        .in_x       (state_reg[in_lane]),
        .busy_lanes (busy_lanes),
        .any_valid  (any_valid),
        .any_last   (any_last),
        .wb         (wb)
    );

    // Final states include the update made by the last transaction itself.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (wb.upd && (wb.lane[LANE_W-1:0] == LANE_W'(i))) begin
                finals[i] = wb.nstate;
            end else begin
                finals[i] = state_reg[i];
            end
        end
        state_next = state_reg;
        if (wb_fire) begin
            if (wb.last) begin
                for (int i = 0; i < LANES; i++) begin
                    state_next[i] = rie_pkg::STATE_RESET;
                end
            end else begin
                state_next = finals;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANES; i++) begin
                state_reg[i] <= rie_pkg::STATE_RESET;
            end
        end else begin
            state_reg <= state_next;
        end
    end

    rie_emit #(.LANES(LANES)) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (wb_fire),
        .load_ready (emit_ready),
        .wb         (wb),
        .finals     (finals),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

// ===== sv/rie_checker.sv =====
// Port-level checker for the rANS encoder, bound to the top level.
// Depends on rie_pkg and rans_interleaved_encoder_top_defines.svh.
`default_nettype none
`include "rans_interleaved_encoder_top_defines.svh"

module rie_checker #(
    parameter int LANES = 4
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire rie_pkg::in_item_t  s_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire rie_pkg::out_item_t m_data
);

    `RIE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `RIE_ASSERT_NOW(a_chunk_width, m_valid && m_data.kind == rie_pkg::KIND_CHUNK, m_data.value[30:16] == '0 && !m_data.end_of_block, "chunk wider than 16 bits or marked end of block")
    `RIE_ASSERT_NOW(a_eob_lane, m_valid && m_data.end_of_block, m_data.kind == rie_pkg::KIND_FINAL && m_data.out_lane == 2'(LANES - 1), "end of block on wrong result")
    `RIE_ASSERT_NEXT(a_last_blocks, s_valid && s_ready && s_data.last, !s_ready, "transaction accepted behind a last transaction")

endmodule

bind rans_interleaved_encoder_top rie_checker #(.LANES(LANES)) u_rie_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the four-way interleaved rANS encoder core.
// Depends on rie_pkg and rans_interleaved_encoder_top; self-checking, no files read.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LANES = 4;

    // Holds its own copy of the lane states and the queue of chunks and final states due.
    class rans_scoreboard;
        logic [rie_pkg::STATE_W-1:0] lane_x[NUM_LANES];
        rie_pkg::out_item_t pending[$];
        int mismatches;

        function new();
            for (int i = 0; i < NUM_LANES; i++) lane_x[i] = rie_pkg::STATE_RESET;
            mismatches = 0;
        endfunction

        function void note_symbol(rie_pkg::in_item_t it);
            logic [63:0] x;
            logic [63:0] limit;
            int ln;
            rie_pkg::out_item_t r;
            ln = it.lane % NUM_LANES;
            if (it.freq != 0 && it.total != 0) begin
                x = lane_x[ln];
                limit = (64'd1 << 31) * it.freq / it.total;
                if (x >= limit) begin
                    r.kind = rie_pkg::KIND_CHUNK;
                    r.out_lane = ln[1:0];
                    r.value = {15'd0, x[15:0]};
                    r.end_of_block = 1'b0;
                    pending.push_back(r);
                    x = x >> 16;
                end
                x = (x / it.freq) * it.total + (x % it.freq) + it.cum_freq;
                lane_x[ln] = x[rie_pkg::STATE_W-1:0];
            end
            if (it.last) begin
                for (int i = 0; i < NUM_LANES; i++) begin
                    r.kind = rie_pkg::KIND_FINAL;
                    r.out_lane = i[1:0];
                    r.value = lane_x[i];
                    r.end_of_block = (i == NUM_LANES - 1);
                    pending.push_back(r);
                    lane_x[i] = rie_pkg::STATE_RESET;
                end
            end
        endfunction

        function void check_output(rie_pkg::out_item_t got);
            rie_pkg::out_item_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected output transaction %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.out_lane !== want.out_lane ||
                got.value !== want.value || got.end_of_block !== want.end_of_block) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    rie_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rie_pkg::out_item_t m_data;

    rans_scoreboard sb = new();
    bit stim_done = 1'b0;

    rans_interleaved_encoder_top #(.LANES(NUM_LANES)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance with valid
    // still high, so a following transaction can be offered without a gap.
    task automatic send_symbol(rie_pkg::in_item_t it);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_symbol(it);
        @(negedge aclk);
    endtask

    task automatic send_fields(int f, int c, int t, int ln, bit lst);
        rie_pkg::in_item_t it;
        it.freq = f[15:0];
        it.cum_freq = c[15:0];
        it.total = t[15:0];
        it.lane = ln[1:0];
        it.last = lst;
        send_symbol(it);
    endtask

    // Mostly a well-formed model symbol; sometimes wrapping or zero-field noise.
    task automatic send_random(int idx, bit lst);
        int t, f, c;
        if ($urandom_range(0, 9) == 0) begin
            send_fields($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 3), lst);
        end else begin
            case ($urandom_range(0, 3))
                0: t = 4096;
                1: t = 65535;
                2: t = $urandom_range(1, 16);
                default: t = $urandom_range(1, 65535);
            endcase
            f = ($urandom_range(0, 2) == 0) ? $urandom_range(1, (t < 8) ? t : 8)
                                            : $urandom_range(1, t);
            c = $urandom_range(0, t - f);
            send_fields(f, c, t, idx % NUM_LANES, lst);
        end
    endtask

    initial begin
        int n;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // Directed: extremes, zero frequency and total, wrapping, lanes, last flag.
        send_fields(1, 0, 65535, 0, 0);
        send_fields(1, 65535, 65535, 1, 0);
        send_fields(65535, 0, 65535, 2, 0);
        send_fields(1, 0, 1, 3, 0);
        send_fields(0, 1234, 100, 0, 0);
        send_fields(5, 7, 0, 1, 0);
        send_fields(65535, 65535, 1, 2, 0);
        send_fields(2, 65535, 65535, 3, 0);
        send_fields(1, 0, 65535, 0, 0);
        send_fields(1, 0, 65535, 0, 0);
        send_fields(3, 1, 65535, 1, 1);
        send_fields(0, 0, 0, 2, 1);
        send_fields(1, 0, 65535, 3, 0);
        send_fields(1, 0, 65535, 3, 0);
        send_fields(1, 0, 2, 3, 1);
        send_fields(32768, 21845, 43690, 1, 1);
        // Random blocks of 1 to 30 symbols each.
        n = 0;
        while (n < 94) begin
            int blen;
            blen = $urandom_range(1, 30);
            if (blen > 94 - n) blen = 94 - n;
            for (int k = blen - 1; k >= 0; k--) begin
                send_random(k, k == 0);
                n++;
                if (n == 50) begin
                    s_valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge aclk);
                    @(negedge aclk);
                end
            end
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        int g;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    m_ready <= 1'b0;
                    repeat (g) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_output(m_data);
    end

    initial begin
        while (!(stim_done && sb.pending.size() == 0)) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/rie_pkg.sv
sv/rie_pipe.sv
sv/rie_emit.sv
sv/rans_interleaved_encoder_top.sv
sv/rie_checker.sv
test/tb_top.sv
